/* rtl/core/ffpra_pkg.sv */
// Shared constants, codes and types of the first-fit page run allocator.
package ffpra_pkg;

   localparam int PAGES      = 1024;
   localparam int PAGE_BYTES = 4096;
   localparam int RECORDS    = 1024;

   localparam int PAGE_W     = $clog2(PAGES);
   localparam int REC_W      = $clog2(RECORDS);
   localparam int LEN_W      = PAGE_W + 1;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int CLR_N      = (PAGES > RECORDS) ? PAGES : RECORDS;
   localparam int SCAN_W     = $clog2(CLR_N) + 1;

   localparam logic [1:0] CSR_AREA_BASE   = 2'd0;
   localparam logic [1:0] CSR_AREA_PAGES  = 2'd1;
   localparam logic [1:0] CSR_BLOCK_LIMIT = 2'd2;
   localparam logic [1:0] CSR_MAX_REQUEST = 2'd3;

   localparam logic OP_ALLOCATE = 1'b0;
   localparam logic OP_FREE     = 1'b1;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NO_RUN  = 3'd1,
      ST_BAD     = 3'd2,
      ST_BLOCK   = 3'd3,
      ST_UNKNOWN = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      SCAN_PAGE_FREE = 2'd0,
      SCAN_REC_EMPTY = 2'd1,
      SCAN_REC_MATCH = 2'd2
   } scan_mode_type;

   typedef struct packed {
      logic                valid;
      logic [PAGE_W-1:0]   start_page;
      logic [LEN_W-1:0]    length;
   } rec_type;

   typedef struct packed {
      logic          clear;
      logic          latch_req;
      logic          scan_start;
      logic          scan_run;
      scan_mode_type scan_mode;
      logic          mark_start;
      logic          mark_step;
      logic          rec_write;
      logic          rsp_load;
      status_type    rsp_status;
      logic          rsp_with_addr;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic op;
      logic bad_size;
      logic block_size;
      logic hit;
      logic scan_end;
      logic mark_last;
      logic rsp_busy;
   } sts_type;

endpackage

/* rtl/core/ffpra_req_if.sv */
// Request channel: operation, size and address words with valid/ready.
interface ffpra_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [22:0] size_bytes;
   logic [31:0] address;

   modport source (output valid, output operation, output size_bytes, output address,
                   input ready);
   modport sink   (input valid, input operation, input size_bytes, input address,
                   output ready);
endinterface

/* rtl/core/ffpra_rsp_if.sv */
// Response channel: status and start address words with valid/ready.
interface ffpra_rsp_if;
   logic                  valid;
   logic                  ready;
   ffpra_pkg::status_type status;
   logic [31:0]           start_address;

   modport source (output valid, output status, output start_address, input ready);
   modport sink   (input valid, input status, input start_address, output ready);
endinterface

/* rtl/core/ffpra_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ffpra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

/* rtl/core/ffpra_dp.sv */
// Datapath: registers, page map and record RAMs, scan counter, response register.
module ffpra_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  ffpra_pkg::cmd_type    cmd,
   output ffpra_pkg::sts_type    sts,
   input  logic                  req_operation,
   input  logic [22:0]           req_size_bytes,
   input  logic [31:0]           req_address,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_data,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output ffpra_pkg::status_type rsp_status,
   output logic [31:0]           rsp_start_address
);
   import ffpra_pkg::*;

   function automatic logic [31:0] page_addr(input logic [31:0] base,
                                             input logic [PAGE_W-1:0] pg);
      return base + (32'(pg) << PAGE_SHIFT);
   endfunction

   logic [31:0] base_ff;
   logic [10:0] area_pages_ff;
   logic [22:0] block_ff, max_ff;

   logic        op_ff;
   logic [22:0] size_ff;
   logic [31:0] addr_ff;

   logic [SCAN_W-1:0] issue_ff, issue_in, pend_idx_ff, pend_idx_in, run_ff, run_in;
   logic              pend_ff, pend_in;
   logic [PAGE_W-1:0] start_ff, start_in, ptr_ff, ptr_in;
   logic [LEN_W-1:0]  len_ff, len_in, rem_ff, rem_in;
   logic [REC_W-1:0]  slot_ff, slot_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff;
   logic [31:0]       rsp_addr_ff;

   logic [31:0]       ap32, np32;
   logic [SCAN_W-1:0] np, limit, found_start;
   logic [39:0]       area_bytes;
   logic [23:0]       need24;
   logic [LEN_W-1:0]  need;
   logic              cond, hit;

   logic              pg_we, pg_wd, pg_rd;
   logic [PAGE_W-1:0] pg_wa;
   logic              rec_we;
   logic [REC_W-1:0]  rec_wa;
   rec_type           rec_wd, rec_rd;

   ffpra_ram #(.WIDTH(1), .DEPTH(PAGES)) u_page_map (
      .clock   (clock),
      .wr_en   (pg_we),
      .wr_addr (pg_wa),
      .wr_data (pg_wd),
      .rd_addr (issue_ff[PAGE_W-1:0]),
      .rd_data (pg_rd)
   );

   ffpra_ram #(.WIDTH($bits(rec_type)), .DEPTH(RECORDS)) u_records (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (rec_wa),
      .wr_data (rec_wd),
      .rd_addr (issue_ff[REC_W-1:0]),
      .rd_data (rec_rd)
   );

   always_comb begin
      ap32       = 32'(area_pages_ff);
      np32       = (ap32 > 32'(PAGES)) ? 32'(PAGES) : ap32;
      np         = np32[SCAN_W-1:0];
      area_bytes = 40'(np32) << PAGE_SHIFT;
      need24     = (24'(size_ff) + 24'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
      need       = need24[LEN_W-1:0];
      limit      = (cmd.scan_mode == SCAN_PAGE_FREE) ? np : SCAN_W'(RECORDS);
      found_start = pend_idx_ff + 1'b1 - SCAN_W'(need);

      case (cmd.scan_mode)
         SCAN_PAGE_FREE: cond = !pg_rd && ((run_ff + 1'b1) == SCAN_W'(need));
         SCAN_REC_EMPTY: cond = !rec_rd.valid;
         SCAN_REC_MATCH: cond = rec_rd.valid &&
                                (page_addr(base_ff, rec_rd.start_page) == addr_ff);
         default:        cond = 1'b0;
      endcase
      hit = pend_ff && cond;

      sts.clr_done   = (issue_ff == SCAN_W'(CLR_N - 1));
      sts.op         = op_ff;
      sts.bad_size   = (size_ff == 23'd0) || (size_ff > max_ff) ||
                       (40'(size_ff) > area_bytes);
      sts.block_size = (size_ff <= block_ff);
      sts.hit        = hit;
      sts.scan_end   = !pend_ff && (issue_ff >= limit);
      sts.mark_last  = (rem_ff == LEN_W'(1));
      sts.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   // scan counter, run length and latched hit information
   always_comb begin
      issue_in    = issue_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      run_in      = run_ff;
      start_in    = start_ff;
      len_in      = len_ff;
      slot_in     = slot_ff;
      ptr_in      = ptr_ff;
      rem_in      = rem_ff;

      if (cmd.clear) begin
         issue_in = issue_ff + 1'b1;
      end
      if (cmd.scan_start) begin
         issue_in = '0;
         pend_in  = 1'b0;
         run_in   = '0;
      end else if (cmd.scan_run) begin
         if (issue_ff < limit) begin
            issue_in    = issue_ff + 1'b1;
            pend_in     = 1'b1;
            pend_idx_in = issue_ff;
         end else begin
            pend_in = 1'b0;
         end
         if (pend_ff) begin
            run_in = pg_rd ? '0 : run_ff + 1'b1;
         end
      end

      if (cmd.scan_run && hit) begin
         case (cmd.scan_mode)
            SCAN_PAGE_FREE: begin
               start_in = found_start[PAGE_W-1:0];
               len_in   = need;
            end
            SCAN_REC_EMPTY: slot_in = pend_idx_ff[REC_W-1:0];
            SCAN_REC_MATCH: begin
               slot_in  = pend_idx_ff[REC_W-1:0];
               start_in = rec_rd.start_page;
               len_in   = rec_rd.length;
            end
            default: ;
         endcase
      end

      if (cmd.mark_start) begin
         ptr_in = start_in;
         rem_in = len_in;
      end else if (cmd.mark_step) begin
         ptr_in = ptr_ff + 1'b1;
         rem_in = rem_ff - 1'b1;
      end

      rsp_valid_in = cmd.rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_comb begin
      pg_we  = cmd.clear ? (issue_ff < SCAN_W'(PAGES)) : cmd.mark_step;
      pg_wa  = cmd.clear ? issue_ff[PAGE_W-1:0] : ptr_ff;
      pg_wd  = !cmd.clear && (op_ff == OP_ALLOCATE);
      rec_we = cmd.clear ? (issue_ff < SCAN_W'(RECORDS)) : cmd.rec_write;
      rec_wa = cmd.clear ? issue_ff[REC_W-1:0] : slot_ff;
      rec_wd = '0;
      if (!cmd.clear && (op_ff == OP_ALLOCATE)) begin
         rec_wd.valid      = 1'b1;
         rec_wd.start_page = start_ff;
         rec_wd.length     = len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= 32'd0;
         area_pages_ff <= 11'd1024;
         block_ff      <= 23'd2048;
         max_ff        <= 23'd4194304;
         issue_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_AREA_BASE:   base_ff       <= csr_data;
               CSR_AREA_PAGES:  area_pages_ff <= csr_data[10:0];
               CSR_BLOCK_LIMIT: block_ff      <= csr_data[22:0];
               CSR_MAX_REQUEST: max_ff        <= csr_data[22:0];
               default: ;
            endcase
         end
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end

      pend_idx_ff <= pend_idx_in;
      run_ff      <= run_in;
      start_ff    <= start_in;
      len_ff      <= len_in;
      slot_ff     <= slot_in;
      ptr_ff      <= ptr_in;
      rem_ff      <= rem_in;
      if (cmd.latch_req) begin
         op_ff   <= req_operation;
         size_ff <= req_size_bytes;
         addr_ff <= req_address;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_addr_ff   <= cmd.rsp_with_addr ? page_addr(base_ff, start_ff) : 32'd0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_start_address = rsp_addr_ff;
endmodule

/* rtl/core/ffpra_ctrl.sv */
// Controller: sequences clear, checks, scans, marking and the response.
module ffpra_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ffpra_pkg::sts_type sts,
   output ffpra_pkg::cmd_type cmd
);
   import ffpra_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_CHECK, S_PSCAN, S_RSCAN, S_FSCAN, S_MARK, S_RECWR, S_FINISH
   } state_type;

   state_type  state_ff, state_in;
   status_type code_ff, code_in;
   logic       with_addr_ff, with_addr_in;

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      with_addr_in = with_addr_ff;
      cmd          = '0;
      req_ready    = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready     = 1'b1;
            cmd.latch_req = req_valid;
            with_addr_in  = 1'b0;
            if (req_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (sts.op == OP_FREE) begin
               cmd.scan_start = 1'b1;
               state_in       = S_FSCAN;
            end else if (sts.bad_size) begin
               code_in  = ST_BAD;
               state_in = S_FINISH;
            end else if (sts.block_size) begin
               code_in  = ST_BLOCK;
               state_in = S_FINISH;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_PSCAN;
            end
         end
         S_PSCAN: begin
            cmd.scan_run  = 1'b1;
            cmd.scan_mode = SCAN_PAGE_FREE;
            if (sts.hit) begin
               // restart the counter for the record table
               cmd.scan_start = 1'b1;
               state_in       = S_RSCAN;
            end else if (sts.scan_end) begin
               code_in  = ST_NO_RUN;
               state_in = S_FINISH;
            end
         end
         S_RSCAN: begin
            cmd.scan_run  = 1'b1;
            cmd.scan_mode = SCAN_REC_EMPTY;
            if (sts.hit) begin
               cmd.mark_start = 1'b1;
               state_in       = S_MARK;
            end else if (sts.scan_end) begin
               code_in  = ST_NO_RUN;
               state_in = S_FINISH;
            end
         end
         S_FSCAN: begin
            cmd.scan_run  = 1'b1;
            cmd.scan_mode = SCAN_REC_MATCH;
            if (sts.hit) begin
               cmd.mark_start = 1'b1;
               state_in       = S_MARK;
            end else if (sts.scan_end) begin
               code_in  = ST_UNKNOWN;
               state_in = S_FINISH;
            end
         end
         S_MARK: begin
            cmd.mark_step = 1'b1;
            if (sts.mark_last) state_in = S_RECWR;
         end
         S_RECWR: begin
            cmd.rec_write = 1'b1;
            code_in       = ST_OK;
            with_addr_in  = (sts.op == OP_ALLOCATE);
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!sts.rsp_busy) begin
               cmd.rsp_load      = 1'b1;
               cmd.rsp_status    = code_ff;
               cmd.rsp_with_addr = with_addr_ff;
               state_in          = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         code_ff      <= ST_OK;
         with_addr_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         with_addr_ff <= with_addr_in;
      end
   end
endmodule

/* rtl/core/first_fit_page_run_allocator.sv */
// First-fit page run allocator: one request at a time, one response word per request.
// After reset the block clears its page map and record table, one entry of each per
// cycle, and accepts no request word meanwhile. An allocate word runs a first-fit
// scan of the page map, a scan of the record table for an empty slot, then marks each
// page of the run and writes its record. A free word scans the record table for a
// matching address, then releases each page of the run and clears its record. Allocates
// refused for their size answer without any scan. The scan rate is set by the single
// read port of each RAM. A finished response waits in an output register while the
// next request word is taken.
module first_fit_page_run_allocator (
   input  logic              clock,
   input  logic              reset,
   ffpra_req_if.sink         req_chan,
   ffpra_rsp_if.source       rsp_chan,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);
   import ffpra_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ffpra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ffpra_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_chan.operation),
      .req_size_bytes    (req_chan.size_bytes),
      .req_address       (req_chan.address),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_status        (rsp_chan.status),
      .rsp_start_address (rsp_chan.start_address)
   );
endmodule

/* rtl/core/ffpra_checker.sv */
// Port-level checker for the allocator, bound to the top level.
module ffpra_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input ffpra_pkg::status_type rsp_status,
   input logic [31:0]           rsp_start_address
);
   import ffpra_pkg::*;

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) &&
                                     $stable(rsp_start_address)))
      else $error("response changed while stalled");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_NO_RUN ||
                     rsp_status == ST_BAD || rsp_status == ST_BLOCK ||
                     rsp_status == ST_UNKNOWN))
      else $error("response status out of range");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_start_address == 32'd0))
      else $error("refused request carries an address");

   a_clear_pass: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while one is at work");
endmodule

bind first_fit_page_run_allocator ffpra_checker u_ffpra_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_start_address (rsp_chan.start_address)
);
